// ===== rtl/rrpa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_pkg
// Shared types and constants of the round-robin port arbiter.
// ----------------------------------------------------------------------------
package rrpa_pkg;

    localparam int MAX_PORTS_DEF = 16;

    localparam int CMD_W        = 2;
    localparam int PORT_W       = 8;
    localparam int SLICE_W      = 4;
    localparam int PPS_W        = 5;
    localparam int PRIO_W       = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;
    localparam int PPS_RESET    = 16;

    localparam logic [PRIO_W-1:0] GRANT_PRIO = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_INDEX     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORTS_PER_SLICE = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAISE    = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_ARB      = 2'd2,
        CMD_CONFLICT = 2'd3
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic execute;
    } t_ctrl;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/rrpa_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_cmd_if
// Command channel: one arbiter command per transaction.
// ----------------------------------------------------------------------------
interface rrpa_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [rrpa_pkg::CMD_W-1:0]   command;
    logic [rrpa_pkg::PORT_W-1:0]  port;
    logic                         conflict_value;

    modport source (output valid, output command, output port, output conflict_value,
                    input ready);
    modport sink   (input valid, input command, input port, input conflict_value,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/rrpa_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_res_if
// Result channel: one result per command transaction.
// ----------------------------------------------------------------------------
interface rrpa_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [rrpa_pkg::PORT_W-1:0]   granted_port;
    logic [rrpa_pkg::PRIO_W-1:0]   grant_priority;
    logic [rrpa_pkg::SLICE_W-1:0]  grant_slice;
    logic                          notify;
    logic                          conflict_flag;

    modport source (output valid, output found, output granted_port, output grant_priority,
                    output grant_slice, output notify, output conflict_flag, input ready);
    modport sink   (input valid, input found, input granted_port, input grant_priority,
                    input grant_slice, input notify, input conflict_flag, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrpa_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rrpa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rrpa_pkg::CFG_IDX_W-1:0]   index;
    logic [rrpa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrpa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_ctrl
// Controller: captures a command, then executes it once the result
// register is free.
// ----------------------------------------------------------------------------
module rrpa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire rrpa_pkg::t_stat i_stat,
    output rrpa_pkg::t_ctrl      o_ctrl
);

    rrpa_pkg::t_state r_state;
    rrpa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrpa_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = rrpa_pkg::S_EXEC;
                end
            end
            rrpa_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = rrpa_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            rrpa_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.load     = i_cmd_valid;
            end
            rrpa_pkg::S_EXEC: begin
                o_ctrl.execute  = i_stat.out_free;
            end
        endcase
    end

    a_exec_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.execute |-> i_stat.out_free)
        else $error("execute issued while result register busy");
    a_load_leads_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> !o_ctrl.in_ready)
        else $error("new command accepted before previous one executed");
    a_no_load_and_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.load && o_ctrl.execute))
        else $error("load and execute in same cycle");

endmodule
`default_nettype wire

// ===== rtl/rrpa_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrpa_datapath
// Request flags, grant pointer, conflict flag, configuration registers,
// rotate-and-priority-encode grant logic and the result register.
// ----------------------------------------------------------------------------
module rrpa_datapath #(
    parameter int MAX_PORTS = rrpa_pkg::MAX_PORTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rrpa_pkg::t_ctrl                     i_ctrl,
    output rrpa_pkg::t_stat                          o_stat,
    input  wire logic [rrpa_pkg::CMD_W-1:0]          i_command,
    input  wire logic [rrpa_pkg::PORT_W-1:0]         i_port,
    input  wire logic                                i_conflict_value,
    input  wire logic                                i_cfg_valid,
    input  wire logic [rrpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rrpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic                                     o_found,
    output logic [rrpa_pkg::PORT_W-1:0]              o_granted_port,
    output logic [rrpa_pkg::PRIO_W-1:0]              o_grant_priority,
    output logic [rrpa_pkg::SLICE_W-1:0]             o_grant_slice,
    output logic                                     o_notify,
    output logic                                     o_conflict_flag
);

    localparam int LW       = $clog2(MAX_PORTS);
    localparam int NW       = $clog2(MAX_PORTS + 1);
    localparam int BW       = rrpa_pkg::SLICE_W + NW;
    localparam int XW       = ((BW > rrpa_pkg::PORT_W) ? BW : rrpa_pkg::PORT_W) + 1;
    localparam int LAST_RST = ((MAX_PORTS < rrpa_pkg::PPS_RESET) ? MAX_PORTS
                                                                  : rrpa_pkg::PPS_RESET) - 1;

    // configuration
    logic [rrpa_pkg::SLICE_W-1:0] r_slice;
    logic [rrpa_pkg::PPS_W-1:0]   r_pps;

    // captured command
    rrpa_pkg::t_cmd               r_cmd;
    logic [rrpa_pkg::PORT_W-1:0]  r_port;
    logic                         r_cval;

    // arbiter state
    logic [MAX_PORTS-1:0]         r_req;
    logic [LW-1:0]                r_last;
    logic                         r_conflict;

    // result register
    logic                         r_out_valid;
    logic                         r_found;
    logic [rrpa_pkg::PORT_W-1:0]  r_gport;
    logic [rrpa_pkg::PRIO_W-1:0]  r_prio;
    logic [rrpa_pkg::SLICE_W-1:0] r_gslice;
    logic                         r_notify;

    logic [NW-1:0]                n_use;
    logic [BW-1:0]                base;
    logic [XW-1:0]                offset;
    logic                         in_slice;
    logic [LW-1:0]                local_idx;
    logic [MAX_PORTS-1:0]         live;
    logic                         any_pending;
    logic [LW:0]                  next_ptr;
    logic [LW-1:0]                start;
    logic                         hi_hit;
    logic                         lo_hit;
    logic [LW-1:0]                hi_idx;
    logic [LW-1:0]                lo_idx;
    logic                         grant_hit;
    logic [LW-1:0]                grant_idx;

    logic [MAX_PORTS-1:0]         n_req;
    logic [LW-1:0]                n_last;
    logic                         n_conflict;
    logic                         n_found;
    logic [rrpa_pkg::PORT_W-1:0]  n_gport;
    logic [rrpa_pkg::PRIO_W-1:0]  n_prio;
    logic [rrpa_pkg::SLICE_W-1:0] n_gslice;
    logic                         n_notify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
            r_pps   <= rrpa_pkg::PPS_W'(rrpa_pkg::PPS_RESET);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rrpa_pkg::CFG_SLICE_INDEX) begin
                r_slice <= i_cfg_data[rrpa_pkg::SLICE_W-1:0];
            end else if (i_cfg_index == rrpa_pkg::CFG_PORTS_PER_SLICE) begin
                r_pps   <= i_cfg_data[rrpa_pkg::PPS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd  <= rrpa_pkg::CMD_RAISE;
            r_port <= '0;
            r_cval <= 1'b0;
        end else if (i_ctrl.load) begin
            r_cmd  <= rrpa_pkg::t_cmd'(i_command);
            r_port <= i_port;
            r_cval <= i_conflict_value;
        end
    end

    // ports in use, slice base and local index
    always_comb begin
        if (r_pps == '0) begin
            n_use = NW'(1);
        end else if (32'(r_pps) > MAX_PORTS) begin
            n_use = NW'(MAX_PORTS);
        end else begin
            n_use = NW'(r_pps);
        end
        base      = BW'(r_slice) * BW'(n_use);
        offset    = XW'(r_port) - XW'(base);
        in_slice  = (XW'(r_port) >= XW'(base)) && (offset < XW'(n_use));
        local_idx = offset[LW-1:0];
    end

    // rotate and priority encode
    always_comb begin
        for (int i = 0; i < MAX_PORTS; i++) begin
            live[i] = r_req[i] && (i < 32'(n_use));
        end
        any_pending = |live;
        next_ptr    = {1'b0, r_last} + (LW+1)'(1);
        start       = (32'(next_ptr) >= 32'(n_use)) ? '0 : next_ptr[LW-1:0];
        hi_hit = 1'b0;
        lo_hit = 1'b0;
        hi_idx = '0;
        lo_idx = '0;
        for (int i = MAX_PORTS - 1; i >= 0; i--) begin
            if (live[i] && (i >= 32'(start))) begin
                hi_hit = 1'b1;
                hi_idx = LW'(i);
            end
            if (live[i]) begin
                lo_hit = 1'b1;
                lo_idx = LW'(i);
            end
        end
        grant_hit = hi_hit || lo_hit;
        grant_idx = hi_hit ? hi_idx : lo_idx;
    end

    always_comb begin
        n_req      = r_req;
        n_last     = r_last;
        n_conflict = r_conflict;
        n_found    = 1'b0;
        n_gport    = '0;
        n_prio     = '0;
        n_gslice   = '0;
        n_notify   = 1'b0;
        unique case (r_cmd)
            rrpa_pkg::CMD_RAISE: begin
                if (in_slice) begin
                    n_notify         = !any_pending;
                    n_req[local_idx] = 1'b1;
                end
            end
            rrpa_pkg::CMD_CLEAR: begin
                if (in_slice) begin
                    n_req[local_idx] = 1'b0;
                end
            end
            rrpa_pkg::CMD_ARB: begin
                if (!r_conflict && grant_hit) begin
                    n_last   = grant_idx;
                    n_found  = 1'b1;
                    n_gport  = rrpa_pkg::PORT_W'(XW'(base) + XW'(grant_idx));
                    n_prio   = rrpa_pkg::GRANT_PRIO;
                    n_gslice = r_slice;
                end
            end
            rrpa_pkg::CMD_CONFLICT: begin
                n_conflict = r_cval;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req      <= '0;
            r_last     <= LW'(LAST_RST);
            r_conflict <= 1'b0;
        end else if (i_ctrl.execute) begin
            r_req      <= n_req;
            r_last     <= n_last;
            r_conflict <= n_conflict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.execute) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.execute) begin
            r_found  <= n_found;
            r_gport  <= n_gport;
            r_prio   <= n_prio;
            r_gslice <= n_gslice;
            r_notify <= n_notify;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_found          = r_found;
    assign o_granted_port   = r_gport;
    assign o_grant_priority = r_prio;
    assign o_grant_slice    = r_gslice;
    assign o_notify         = r_notify;
    assign o_conflict_flag  = r_conflict;

    a_ptr_follows_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.execute && n_found |=> r_last == $past(grant_idx))
        else $error("pointer not moved to granted port");
    a_conflict_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.execute && r_conflict && (r_cmd == rrpa_pkg::CMD_ARB) |=> $stable(r_last))
        else $error("pointer moved while conflict held");
    a_notify_only_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.execute && n_notify |-> (r_cmd == rrpa_pkg::CMD_RAISE) && in_slice)
        else $error("notify without an in-slice raise");
    a_grant_is_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.execute && n_found |-> live[grant_idx])
        else $error("grant to a port without a pending request");

endmodule
`default_nettype wire

// ===== rtl/round_robin_port_arbiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_port_arbiter
// Round-robin arbiter over the ports of one buffer slice.
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one result transaction. A command
// is captured into the command registers and is executed once the result
// register is free, when the result register is loaded. The block accepts
// the next command while the previous result waits on the output.
// Arbitrate grants the first requesting port after the last granted one,
// unless the conflict flag is held (rotate plus priority encoder over the
// request flags). Configuration writes are accepted in any cycle.
// ----------------------------------------------------------------------------
module round_robin_port_arbiter #(
    parameter int MAX_PORTS = rrpa_pkg::MAX_PORTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrpa_cmd_if.sink   i_cmd,
    rrpa_cfg_if.sink   i_cfg,
    rrpa_res_if.source o_res
);

    rrpa_pkg::t_ctrl ctrl;
    rrpa_pkg::t_stat stat;

    assign i_cmd.ready = ctrl.in_ready;
    assign i_cfg.ready = 1'b1;

    rrpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    rrpa_datapath #(
        .MAX_PORTS (MAX_PORTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_command        (i_cmd.command),
        .i_port           (i_cmd.port),
        .i_conflict_value (i_cmd.conflict_value),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_found          (o_res.found),
        .o_granted_port   (o_res.granted_port),
        .o_grant_priority (o_res.grant_priority),
        .o_grant_slice    (o_res.grant_slice),
        .o_notify         (o_res.notify),
        .o_conflict_flag  (o_res.conflict_flag)
    );

endmodule
`default_nettype wire

// ===== bench/rrpa_checker.sv =====
// ----------------------------------------------------------------------------
// rrpa_checker
// Watches the command, configuration and result channels of the round-robin
// port arbiter. It keeps its own copy of the request flags, the grant pointer,
// the conflict flag and the registers, works out the result of each accepted
// command transaction, and compares every result transaction field by field
// against the oldest expected one. It reports the number of failures and the
// number of results still expected.
// ----------------------------------------------------------------------------
module rrpa_checker
    import rrpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrpa_cmd_if       i_cmd,
    rrpa_cfg_if       i_cfg,
    rrpa_res_if       i_res,
    output int        o_fail_count,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                found;
        logic [PORT_W-1:0]   granted_port;
        logic [PRIO_W-1:0]   grant_priority;
        logic [SLICE_W-1:0]  grant_slice;
        logic                notify;
        logic                conflict_flag;
    } t_arb_outcome;

    logic [SLICE_W-1:0] slice_reg;
    logic [PPS_W-1:0]   pps_reg;
    logic               req_flags [MAX_PORTS_DEF];
    int                 last_grant;
    logic               conflict_hold;

    t_arb_outcome       expected_outcomes [$];
    int                 mismatch_count;

    function automatic int active_ports();
        if (pps_reg == '0) begin
            return 1;
        end
        if (int'(pps_reg) > MAX_PORTS_DEF) begin
            return MAX_PORTS_DEF;
        end
        return int'(pps_reg);
    endfunction

    // Applies one command to the model state and returns what the block must report.
    function automatic t_arb_outcome apply_arbiter_cmd(t_cmd cmd, logic [PORT_W-1:0] gport,
                                                       logic cval);
        t_arb_outcome res;
        int n;
        int base;
        int loc;
        int p;
        logic hit;
        n    = active_ports();
        base = int'(slice_reg) * n;
        loc  = int'(gport) - base;
        res  = '{found: 1'b0, granted_port: '0, grant_priority: '0, grant_slice: '0,
                 notify: 1'b0, conflict_flag: 1'b0};
        hit  = 1'b0;
        case (cmd)
            CMD_RAISE: begin
                if (loc >= 0 && loc < n) begin
                    res.notify = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        if (req_flags[i]) begin
                            res.notify = 1'b0;
                        end
                    end
                    req_flags[loc] = 1'b1;
                end
            end
            CMD_CLEAR: begin
                if (loc >= 0 && loc < n) begin
                    req_flags[loc] = 1'b0;
                end
            end
            CMD_ARB: begin
                if (!conflict_hold) begin
                    p = last_grant + 1;
                    if (p >= n) begin
                        p = 0;
                    end
                    for (int k = 0; k < n; k++) begin
                        if (!hit && req_flags[p]) begin
                            hit                = 1'b1;
                            last_grant         = p;
                            res.found          = 1'b1;
                            res.granted_port   = PORT_W'(base + p);
                            res.grant_priority = GRANT_PRIO;
                            res.grant_slice    = slice_reg;
                        end
                        if (!hit) begin
                            p = (p + 1 >= n) ? 0 : p + 1;
                        end
                    end
                end
            end
            default: begin
                conflict_hold = cval;
            end
        endcase
        res.conflict_flag = conflict_hold;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_arb_outcome exp_res;
        t_arb_outcome got_res;
        if (!i_rst_n) begin
            slice_reg     = '0;
            pps_reg       = PPS_W'(PPS_RESET);
            for (int i = 0; i < MAX_PORTS_DEF; i++) begin
                req_flags[i] = 1'b0;
            end
            last_grant    = active_ports() - 1;
            conflict_hold = 1'b0;
            expected_outcomes.delete();
            o_outstanding  <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_res = '{found: i_res.found, granted_port: i_res.granted_port,
                            grant_priority: i_res.grant_priority,
                            grant_slice: i_res.grant_slice, notify: i_res.notify,
                            conflict_flag: i_res.conflict_flag};
                if (expected_outcomes.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] result transaction with nothing expected", $realtime);
                    end
                end else begin
                    exp_res = expected_outcomes.pop_front();
                    if (got_res.found !== exp_res.found
                        || got_res.granted_port !== exp_res.granted_port
                        || got_res.grant_priority !== exp_res.grant_priority
                        || got_res.grant_slice !== exp_res.grant_slice
                        || got_res.notify !== exp_res.notify
                        || got_res.conflict_flag !== exp_res.conflict_flag) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("[%0t] mismatch exp found=%0d port=%0d prio=%0d slice=%0d",
                                     $realtime, exp_res.found, exp_res.granted_port,
                                     exp_res.grant_priority, exp_res.grant_slice,
                                     " notify=%0d conflict=%0d", exp_res.notify,
                                     exp_res.conflict_flag);
                            $display("    got found=%0d port=%0d prio=%0d slice=%0d",
                                     got_res.found, got_res.granted_port,
                                     got_res.grant_priority, got_res.grant_slice,
                                     " notify=%0d conflict=%0d", got_res.notify,
                                     got_res.conflict_flag);
                        end
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_SLICE_INDEX) begin
                    slice_reg = i_cfg.data[SLICE_W-1:0];
                end else if (i_cfg.index == CFG_PORTS_PER_SLICE) begin
                    pps_reg = i_cfg.data[PPS_W-1:0];
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_outcomes.push_back(apply_arbiter_cmd(t_cmd'(i_cmd.command), i_cmd.port,
                                                              i_cmd.conflict_value));
            end
            o_outstanding <= expected_outcomes.size();
        end
        o_fail_count <= mismatch_count;
    end

    initial begin
        mismatch_count = 0;
        o_fail_count   = 0;
        o_outstanding  = 0;
    end

endmodule

// ===== bench/tb_round_robin_port_arbiter.sv =====
// ----------------------------------------------------------------------------
// tb_round_robin_port_arbiter
// Drives the round-robin port arbiter with a directed sequence covering empty
// arbitration, notify, wrap-around, conflict hold, out-of-slice ports and a
// stale pointer, then with random command transactions under a series of
// slice settings and idle patterns. The checker does all the comparing; this
// module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_port_arbiter;
    timeunit 1ns;
    timeprecision 1ps;
    import rrpa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEG_ITEMS    = 58;
    localparam int SEGS_PER_MODE = 4;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   fail_count;
    int   outstanding;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cur_slice;
    int   cur_pps;

    rrpa_cmd_if cmd_bus ();
    rrpa_cfg_if cfg_bus ();
    rrpa_res_if res_bus ();

    round_robin_port_arbiter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    rrpa_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_bus),
        .i_cfg         (cfg_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_cmd(input t_cmd cmd, input logic [PORT_W-1:0] port, input logic cval);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.command        <= cmd;
        cmd_bus.port           <= port;
        cmd_bus.conflict_value <= cval;
        do @(posedge i_clk); while (!cmd_bus.ready);
        @(negedge i_clk);
    endtask

    // Holds off commands until every expected result has come back.
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_slice(input int slice, input int pps);
        write_reg(CFG_SLICE_INDEX, slice);
        write_reg(CFG_PORTS_PER_SLICE, pps);
        cur_slice = slice;
        cur_pps   = pps;
    endtask

    // Mostly ports inside the current slice, some just outside, some anywhere.
    function automatic logic [PORT_W-1:0] pick_port();
        int n;
        int base;
        int r;
        n    = (cur_pps == 0) ? 1 : ((cur_pps > MAX_PORTS_DEF) ? MAX_PORTS_DEF : cur_pps);
        base = cur_slice * n;
        r    = $urandom_range(99);
        if (r < 80) begin
            return PORT_W'(base + $urandom_range(n - 1));
        end else if (r < 85) begin
            return PORT_W'(base + n);
        end else if (r < 90) begin
            return PORT_W'(base - 1);
        end
        return PORT_W'($urandom_range(255));
    endfunction

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            send_cmd(CMD_RAISE, pick_port(), 1'($urandom_range(1)));
        end else if (r < 50) begin
            send_cmd(CMD_CLEAR, pick_port(), 1'($urandom_range(1)));
        end else if (r < 90) begin
            send_cmd(CMD_ARB, PORT_W'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            send_cmd(CMD_CONFLICT, PORT_W'($urandom_range(255)), ($urandom_range(99) < 40));
        end
    endtask

    initial begin
        int seg_id;
        i_rst_n                = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.command        = CMD_RAISE;
        cmd_bus.port           = '0;
        cmd_bus.conflict_value = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_SLICE_INDEX;
        cfg_bus.data           = '0;
        res_bus.ready          = 1'b0;
        send_idle_pct          = 8;
        recv_idle_pct          = 68;
        cur_slice              = 0;
        cur_pps                = PPS_RESET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, pointer on the last port
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_RAISE, 8'd0, 1'b0);
        send_cmd(CMD_RAISE, 8'd15, 1'b0);
        send_cmd(CMD_RAISE, 8'd255, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_CONFLICT, 8'd0, 1'b1);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_RAISE, 8'd7, 1'b0);
        send_cmd(CMD_CONFLICT, 8'd255, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_CLEAR, 8'd0, 1'b0);
        send_cmd(CMD_CLEAR, 8'd200, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_CLEAR, 8'd15, 1'b0);
        send_cmd(CMD_CLEAR, 8'd7, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_RAISE, 8'd16, 1'b0);
        drain();

        // top slice reaching port 255, then a shrink that leaves the pointer stale
        set_slice(15, 16);
        send_cmd(CMD_RAISE, 8'd255, 1'b0);
        send_cmd(CMD_RAISE, 8'd240, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        drain();
        set_slice(15, 4);
        send_cmd(CMD_ARB, 8'd0, 1'b0);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 68;
                end
                1: begin
                    send_idle_pct = 68;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
                drain();
                seg_id = mode * SEGS_PER_MODE + seg;
                case (seg_id)
                    0: set_slice(0, 16);
                    1: set_slice(15, 31);
                    2: set_slice(7, 0);
                    3: set_slice(3, 1);
                    4: set_slice(15, 17);
                    5: set_slice(0, 2);
                    default: set_slice($urandom_range(15), $urandom_range(31));
                endcase
                for (int k = 0; k < SEG_ITEMS; k++) begin
                    send_random();
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rrpa_pkg.sv
rtl/rrpa_cmd_if.sv
rtl/rrpa_res_if.sv
rtl/rrpa_cfg_if.sv
rtl/rrpa_ctrl.sv
rtl/rrpa_datapath.sv
rtl/round_robin_port_arbiter.sv
bench/rrpa_checker.sv
bench/tb_round_robin_port_arbiter.sv
